### src/tlpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and codes for the two-level priority ticket queue.
// No dependencies.
package tlpq_pkg;

  localparam int TICKET_W = 5;
  localparam int LIMIT_W  = 5;
  localparam logic [LIMIT_W-1:0] QUEUE_LIMIT_RST = 5'd10;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_FIND   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_e;

  // One queue slot as held in the entry RAM.
  typedef struct packed {
    logic [TICKET_W-1:0] ticket;
    logic                gold;
  } entry_t;

endpackage
`default_nettype wire

### src/tlpq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tlpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

### src/two_level_priority_ticket_queue_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Two-level priority ticket queue: ordered entry store in one RAM plus a walker FSM.
// Depends on tlpq_pkg and tlpq_ram.
//
// Usage:
//   Input stream (s_axis_*): one transaction per request. tuser carries the
//   request kind (add / remove / find) and the gold flag, tdata the ticket.
//   Output stream (m_axis_*): exactly one transaction per request, in order,
//   with the status in tuser and ticket, category and entry count in tdata.
//   Config: cfg_we_i writes queue_limit; only write while the block is idle.
// Timing:
//   Entries live in a RAM with one read and one write port. Requests walk it
//   one slot per cycle, so the cost is set by that single read port:
//     standard add, refused add, lookup on empty queue: no walk
//     gold add: walks back over standard entries
//     find: walks forward until a hit, remove: walks every filled slot (it compacts the tail)
//   One request is in flight at a time; the next one is taken in the cycle
//   the result lands in the output register.
// Reset: count cleared, limit back to 10, output empty. RAM content is not
//   cleared; only slots below the count are ever read.
// Stall: a result waits in the output register while m_axis_tready_i is low;
//   the next request may be accepted and processed up to its result.
module two_level_priority_ticket_queue_unit
  import tlpq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config
  input  wire logic        cfg_we_i,
  input  wire logic [4:0]  cfg_wdata_i,      // queue_limit
  // request stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [4:0] ticket, [7:5] zero
  input  wire logic [2:0]  s_axis_tuser_i,   // [1:0] kind, [2] gold
  // result stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [15:0] m_axis_tdata_o,   // [4:0] result_ticket, [5] found_gold,
                                             // [10:6] entry_total, [15:11] zero
  output logic      [1:0]  m_axis_tuser_o    // [1:0] status
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam int EW = $bits(entry_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,   // forward walk: find / remove with compaction
    S_BACK,   // backward walk: gold insert, shifting standard entries up
    S_PLACE,  // gold insert lands at slot 0
    S_DONE    // hand result to the output register
  } state_e;

  state_e                state_q, state_d;
  kind_e                 kind_q, kind_d;
  logic [TICKET_W-1:0]   ticket_q, ticket_d;
  logic                  found_q, found_d;
  logic                  fgold_q, fgold_d;
  status_e               status_q, status_d;
  logic [AW-1:0]         ptr_q, ptr_d;
  logic [CW-1:0]         fill_q, fill_d;
  logic [LIMIT_W-1:0]    limit_q, limit_d;
  logic                  m_valid_q, m_valid_d;
  logic [15:0]           m_data_q, m_data_d;
  logic [1:0]            m_user_q, m_user_d;

  // RAM port signals
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  entry_t                ram_wdata, rdata;
  logic [EW-1:0]         ram_rdata;

  // Request decode
  kind_e                 in_kind;
  logic                  in_gold;
  logic [TICKET_W-1:0]   in_ticket;
  logic                  accept;

  logic [LW-1:0]         fill_ext;
  logic [TICKET_W-1:0]   new_ticket;
  logic                  is_full;
  logic [CW-1:0]         ptr_nx;
  logic                  hit;

  assign in_kind   = kind_e'(s_axis_tuser_i[1:0]);
  assign in_gold   = s_axis_tuser_i[2];
  assign in_ticket = s_axis_tdata_i[TICKET_W-1:0];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign fill_ext   = LW'(fill_q);
  assign new_ticket = TICKET_W'(fill_ext + LW'(1));
  // limit above DEPTH behaves as DEPTH
  assign is_full    = (fill_ext >= LW'(limit_q)) || (fill_q >= CW'(DEPTH));

  assign rdata  = entry_t'(ram_rdata);
  assign ptr_nx = CW'(ptr_q) + CW'(1);
  assign hit    = !found_q && (rdata.ticket == ticket_q);

  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    ticket_d  = ticket_q;
    found_d   = found_q;
    fgold_d   = fgold_q;
    status_d  = status_q;
    ptr_d     = ptr_q;
    fill_d    = fill_q;
    limit_d   = cfg_we_i ? cfg_wdata_i : limit_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          kind_d   = in_kind;
          ticket_d = in_ticket;
          found_d  = 1'b0;
          fgold_d  = 1'b0;
          if (in_kind == KIND_ADD) begin
            if (is_full) begin
              status_d = ST_FULL;
              ticket_d = '0;
              state_d  = S_DONE;
            end else begin
              status_d = ST_DONE;
              ticket_d = new_ticket;
              fgold_d  = in_gold;
              fill_d   = fill_q + CW'(1);
              if (in_gold && (fill_q != '0)) begin
                ram_raddr = AW'(fill_q - CW'(1));
                ptr_d     = AW'(fill_q - CW'(1));
                state_d   = S_BACK;
              end else begin
                // append at the tail
                ram_we           = 1'b1;
                ram_waddr        = AW'(fill_q);
                ram_wdata.ticket = new_ticket;
                ram_wdata.gold   = in_gold;
                state_d          = S_DONE;
              end
            end
          end else if (fill_q == '0) begin
            status_d = ST_MISSING;
            state_d  = S_DONE;
          end else begin
            ram_raddr = '0;
            ptr_d     = '0;
            state_d   = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // after a removal hit, every later slot moves down by one
        if (found_q) begin
          ram_we    = 1'b1;
          ram_waddr = ptr_q - AW'(1);
          ram_wdata = rdata;
        end
        if (hit) begin
          found_d = 1'b1;
          fgold_d = rdata.gold;
        end
        if (hit && (kind_q != KIND_REMOVE)) begin
          status_d = ST_DONE;
          state_d  = S_DONE;
        end else if (ptr_nx >= fill_q) begin
          if (found_q || hit) begin
            status_d = ST_DONE;
            fill_d   = fill_q - CW'(1);
          end else begin
            status_d = ST_MISSING;
          end
          state_d = S_DONE;
        end else begin
          ram_raddr = AW'(ptr_nx);
          ptr_d     = AW'(ptr_nx);
        end
      end

      S_BACK: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q + AW'(1);
        if (!rdata.gold) begin
          ram_wdata = rdata;
          if (ptr_q == '0) begin
            state_d = S_PLACE;
          end else begin
            ram_raddr = ptr_q - AW'(1);
            ptr_d     = ptr_q - AW'(1);
          end
        end else begin
          ram_wdata.ticket = ticket_q;
          ram_wdata.gold   = 1'b1;
          state_d          = S_DONE;
        end
      end

      S_PLACE: begin
        ram_we           = 1'b1;
        ram_waddr        = ptr_q;
        ram_wdata.ticket = ticket_q;
        ram_wdata.gold   = 1'b1;
        state_d          = S_DONE;
      end

      S_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = {5'b0, TICKET_W'(fill_ext), fgold_q, ticket_q};
          m_user_d  = status_q;
          state_d   = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      fill_q    <= '0;
      limit_q   <= QUEUE_LIMIT_RST;
      m_valid_q <= 1'b0;
      found_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      limit_q   <= limit_d;
      m_valid_q <= m_valid_d;
      found_q   <= found_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    ticket_q <= ticket_d;
    fgold_q  <= fgold_d;
    status_q <= status_d;
    ptr_q    <= ptr_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  tlpq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule
`default_nettype wire
